// File: rtl/epoch_seconds_to_utc_date_macros.svh
// ============================================================================
// Assertion macros for the epoch-to-calendar converter
// Shared property wrappers on clk with a synchronous active-low reset.
// ============================================================================
`ifndef EPOCH_SECONDS_TO_UTC_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ESU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ESU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/esu_pkg.sv
// ============================================================================
// esu_pkg
// Constants and types for the epoch-seconds to UTC calendar converter.
// ============================================================================
package esu_pkg;

  // Pipeline depth: register stages from input to output register
  localparam int NSTG = 11;

  // Clock-of-day constants
  localparam logic [5:0] SEC_PER_MIN = 6'd60;
  localparam logic [5:0] MIN_PER_HR  = 6'd60;
  localparam logic [4:0] HR_PER_DAY  = 5'd24;
  localparam logic [2:0] DAYS_PER_WK = 3'd7;
  localparam logic [2:0] WDAY_OFS    = 3'd4;   // 1970-01-01 was a Thursday

  // Reciprocal multipliers: q = (x * M) >> SH, exact over the input range
  localparam logic [31:0] DIV60_M  = 32'h8888_8889;  // any 32-bit x
  localparam int          DIV60_SH = 37;
  localparam logic [20:0] DIV24_M  = 21'd1398102;    // x < 2^21
  localparam int          DIV24_SH = 25;
  localparam logic [17:0] DIV7_M   = 18'd149797;     // x < 349525
  localparam int          DIV7_SH  = 20;
  localparam logic [15:0] DIV4Y_M  = 16'd45934;      // x < 94519
  localparam int          DIV4Y_SH = 26;

  // Day-count constants, days rebased to 0000-03-01
  localparam int          DAYS_0000_TO_1970 = 719468;
  localparam int          DAYS_PER_400Y     = 146097;
  localparam int          DAYS_PER_100Y     = 36524;
  localparam int          DAYS_PER_4Y       = 1461;
  localparam int          DAYS_PER_YR       = 365;
  localparam int          DAYS_PER_5MON     = 153;
  localparam int          DAYS_PER_2MON     = 61;
  localparam int          DAYS_PER_MON      = 31;
  localparam int          DAYS_MAR_TO_DEC   = 31 + 30 + 31 + 30 + 31 + 31 + 30 + 31 + 30 + 31;
  localparam int          DAYS_JAN_FEB      = 59;

  // Every input lands in 400-year era 4 or 5: strip four eras up front
  localparam logic [17:0] DAY_OFS_CYC4 = 18'(DAYS_0000_TO_1970 - 4 * DAYS_PER_400Y);

  // Year arithmetic, kept modulo 256 relative to 1900
  localparam int          YEAR_BASE   = 1900;
  localparam logic [7:0]  CYC4_YR_OFS = 8'(4 * 400 - YEAR_BASE);
  localparam logic [7:0]  CYC5_YR_OFS = 8'(5 * 400 - YEAR_BASE);
  localparam logic [7:0]  NONLEAP_CENT = 8'(2100 - YEAR_BASE);  // only century in range

  // March-based month index at which the calendar year rolls over
  localparam logic [3:0]  MON_JAN_MAR = 4'd10;
  localparam logic [3:0]  MON_MAR_OFS = 4'd2;

  // Time-of-day fields carried down the pipeline
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
  } tod_t;

endpackage

// File: rtl/epoch_seconds_to_utc_date.sv
// ============================================================================
// epoch_seconds_to_utc_date
// Converts unsigned seconds since 1970-01-01 UTC into the broken-down
// Gregorian date and time, in an eleven-stage pipeline.
// ============================================================================
//
//  channel  handshake            payload
//  -------  -------------------  -----------------------------------------
//  in       in_valid / in_stall  in_epoch_seconds
//  out      out_valid/out_stall  out_second .. out_year_day (8 fields)
//
//  Eleven register stages: an accepted input is registered in stage 1,
//  moves through stages 2 to 10, and out_valid rises once it reaches stage 11.
//  One transaction enters per cycle while in_stall is low; every stage
//  advances each cycle unless out_stall holds it. Divisions by 60, 24, 7
//  and 1461 are reciprocal multiplies, the others compare chains, and each
//  fits inside one stage. Reset clears only the stage valid bits; payload
//  registers are not reset. Stages advance independently: an empty stage
//  loads even while the output register is stalled, so bubbles collapse
//  and in_stall rises only when every stage holds a transaction.
`include "epoch_seconds_to_utc_date_macros.svh"

module epoch_seconds_to_utc_date
  import esu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_month_day,
  output logic [3:0]  out_month_index,
  output logic [7:0]  out_years_since_1900,
  output logic [8:0]  out_year_day
);

  // --------------------------------------------------------------------------
  // Stage valid bits and per-stage load enables
  // --------------------------------------------------------------------------
  logic [NSTG:1] v_r;
  logic [NSTG:1] v_in;
  logic [NSTG:1] ld;

  assign v_in = {v_r[NSTG-1:1], in_valid};

  // Load a stage when it is empty or its contents move on
  always_comb begin
    ld[NSTG] = !v_r[NSTG] || !out_stall;
    for (int i = NSTG - 1; i >= 1; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  assign in_stall  = !ld[1];
  assign out_valid = v_r[NSTG];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 1; i <= NSTG; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: seconds / 60
  // --------------------------------------------------------------------------
  logic [63:0] s1_prod;
  logic [31:0] s1_t_r;
  logic [26:0] s1_q1_r;

  assign s1_prod = 64'(in_epoch_seconds) * 64'(DIV60_M);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_t_r  <= in_epoch_seconds;
      s1_q1_r <= s1_prod[63:DIV60_SH];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: second remainder, minutes / 60
  // --------------------------------------------------------------------------
  logic [31:0] s2_q1x60;
  logic [63:0] s2_prod;
  tod_t        s2_tod_nxt;
  tod_t        s2_tod_r;
  logic [26:0] s2_q1_r;
  logic [20:0] s2_q2_r;

  assign s2_q1x60 = 32'(s1_q1_r) * 32'(SEC_PER_MIN);
  assign s2_prod  = 64'(s1_q1_r) * 64'(DIV60_M);

  always_comb begin
    s2_tod_nxt        = '0;
    s2_tod_nxt.second = 6'(s1_t_r - s2_q1x60);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_tod_r <= s2_tod_nxt;
      s2_q1_r  <= s1_q1_r;
      s2_q2_r  <= s2_prod[DIV60_SH+20:DIV60_SH];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: minute remainder, hours / 24
  // --------------------------------------------------------------------------
  logic [26:0] s3_q2x60;
  logic [41:0] s3_prod;
  tod_t        s3_tod_nxt;
  tod_t        s3_tod_r;
  logic [20:0] s3_q2_r;
  logic [15:0] s3_days_r;

  assign s3_q2x60 = 27'(s2_q2_r) * 27'(MIN_PER_HR);
  assign s3_prod  = 42'(s2_q2_r) * 42'(DIV24_M);

  always_comb begin
    s3_tod_nxt        = s2_tod_r;
    s3_tod_nxt.minute = 6'(s2_q1_r - s3_q2x60);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_tod_r  <= s3_tod_nxt;
      s3_q2_r   <= s2_q2_r;
      s3_days_r <= s3_prod[DIV24_SH+15:DIV24_SH];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: hour remainder, weekday / 7, day within 400-year cycle
  // --------------------------------------------------------------------------
  logic [20:0] s4_daysx24;
  logic [15:0] s4_wx;
  logic [33:0] s4_prod;
  logic [17:0] s4_dsum;
  logic        s4_cyc5;
  logic [17:0] s4_doc;
  tod_t        s4_tod_nxt;
  tod_t        s4_tod_r;
  logic [15:0] s4_wx_r;
  logic [12:0] s4_wq_r;
  logic [17:0] s4_doc_r;
  logic        s4_cyc5_r;

  assign s4_daysx24 = 21'(s3_days_r) * 21'(HR_PER_DAY);
  assign s4_wx      = s3_days_r + 16'(WDAY_OFS);
  assign s4_prod    = 34'(s4_wx) * 34'(DIV7_M);
  assign s4_dsum    = 18'(s3_days_r) + DAY_OFS_CYC4;
  assign s4_cyc5    = (s4_dsum >= 18'(DAYS_PER_400Y));
  assign s4_doc     = s4_cyc5 ? 18'(s4_dsum - 18'(DAYS_PER_400Y)) : s4_dsum;

  always_comb begin
    s4_tod_nxt      = s3_tod_r;
    s4_tod_nxt.hour = 5'(s3_q2_r - s4_daysx24);
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_tod_r  <= s4_tod_nxt;
      s4_wx_r   <= s4_wx;
      s4_wq_r   <= s4_prod[DIV7_SH+12:DIV7_SH];
      s4_doc_r  <= s4_doc;
      s4_cyc5_r <= s4_cyc5;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: weekday remainder, century split
  // The final leap day of a 400-year cycle falls out as century 3 with a
  // full 36524-day remainder, which the year clamp below maps to day 365.
  // --------------------------------------------------------------------------
  logic [15:0] s5_wqx7;
  logic [1:0]  s5_cent;
  logic [17:0] s5_centdays;
  tod_t        s5_tod_nxt;
  tod_t        s5_tod_r;
  logic [1:0]  s5_cent_r;
  logic [15:0] s5_dic_r;
  logic        s5_cyc5_r;

  assign s5_wqx7 = 16'(s4_wq_r) * 16'(DAYS_PER_WK);

  always_comb begin
    if (s4_doc_r >= 18'(3 * DAYS_PER_100Y)) begin
      s5_cent = 2'd3;
    end else if (s4_doc_r >= 18'(2 * DAYS_PER_100Y)) begin
      s5_cent = 2'd2;
    end else if (s4_doc_r >= 18'(DAYS_PER_100Y)) begin
      s5_cent = 2'd1;
    end else begin
      s5_cent = 2'd0;
    end
    s5_centdays        = 18'(s5_cent) * 18'(DAYS_PER_100Y);
    s5_tod_nxt         = s4_tod_r;
    s5_tod_nxt.weekday = 3'(s4_wx_r - s5_wqx7);
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_tod_r  <= s5_tod_nxt;
      s5_cent_r <= s5_cent;
      s5_dic_r  <= 16'(s4_doc_r - s5_centdays);
      s5_cyc5_r <= s4_cyc5_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: 4-year split (day in century / 1461)
  // --------------------------------------------------------------------------
  logic [31:0] s6_prod;
  tod_t        s6_tod_r;
  logic [1:0]  s6_cent_r;
  logic [15:0] s6_dic_r;
  logic        s6_cyc5_r;
  logic [4:0]  s6_qyear_r;

  assign s6_prod = 32'(s5_dic_r) * 32'(DIV4Y_M);

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s6_tod_r   <= s5_tod_r;
      s6_cent_r  <= s5_cent_r;
      s6_dic_r   <= s5_dic_r;
      s6_cyc5_r  <= s5_cyc5_r;
      s6_qyear_r <= s6_prod[DIV4Y_SH+4:DIV4Y_SH];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: day within 4-year group, year base relative to 1900
  // --------------------------------------------------------------------------
  logic [15:0] s7_qydays;
  logic [7:0]  s7_base;
  tod_t        s7_tod_r;
  logic [10:0] s7_diqy_r;
  logic [7:0]  s7_base_r;

  assign s7_qydays = 16'(s6_qyear_r) * 16'(DAYS_PER_4Y);
  assign s7_base   = 8'(8'(s6_cent_r) * 8'd100 + 8'(s6_qyear_r) * 8'd4)
                   + (s6_cyc5_r ? CYC5_YR_OFS : CYC4_YR_OFS);

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s7_tod_r  <= s6_tod_r;
      s7_diqy_r <= 11'(s6_dic_r - s7_qydays);
      s7_base_r <= s7_base;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: year within group, clamped to 3 for the 4-year leap day
  // --------------------------------------------------------------------------
  logic [1:0]  s8_yr;
  tod_t        s8_tod_r;
  logic [8:0]  s8_diy_r;
  logic [7:0]  s8_ymar_r;

  always_comb begin
    if (s7_diqy_r >= 11'(3 * DAYS_PER_YR)) begin
      s8_yr = 2'd3;
    end else if (s7_diqy_r >= 11'(2 * DAYS_PER_YR)) begin
      s8_yr = 2'd2;
    end else if (s7_diqy_r >= 11'(DAYS_PER_YR)) begin
      s8_yr = 2'd1;
    end else begin
      s8_yr = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      s8_tod_r  <= s7_tod_r;
      s8_diy_r  <= 9'(s7_diqy_r - 11'(s8_yr) * 11'(DAYS_PER_YR));
      s8_ymar_r <= s7_base_r + 8'(s8_yr);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: five-month split, leap flag of the March-based year
  // --------------------------------------------------------------------------
  logic [1:0]  s9_qmon;
  tod_t        s9_tod_r;
  logic [8:0]  s9_diy_r;
  logic [7:0]  s9_ymar_r;
  logic [1:0]  s9_qmon_r;
  logic [7:0]  s9_r1_r;
  logic        s9_leap_r;

  always_comb begin
    if (s8_diy_r >= 9'(2 * DAYS_PER_5MON)) begin
      s9_qmon = 2'd2;
    end else if (s8_diy_r >= 9'(DAYS_PER_5MON)) begin
      s9_qmon = 2'd1;
    end else begin
      s9_qmon = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      s9_tod_r  <= s8_tod_r;
      s9_diy_r  <= s8_diy_r;
      s9_ymar_r <= s8_ymar_r;
      s9_qmon_r <= s9_qmon;
      s9_r1_r   <= 8'(s8_diy_r - 9'(s9_qmon) * 9'(DAYS_PER_5MON));
      s9_leap_r <= (s8_ymar_r[1:0] == 2'd0) && (s8_ymar_r != NONLEAP_CENT);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: two-month split
  // --------------------------------------------------------------------------
  logic [1:0]  s10_bmon;
  tod_t        s10_tod_r;
  logic [8:0]  s10_diy_r;
  logic [7:0]  s10_ymar_r;
  logic        s10_leap_r;
  logic [5:0]  s10_r2_r;
  logic [3:0]  s10_mon_r;

  always_comb begin
    if (s9_r1_r >= 8'(2 * DAYS_PER_2MON)) begin
      s10_bmon = 2'd2;
    end else if (s9_r1_r >= 8'(DAYS_PER_2MON)) begin
      s10_bmon = 2'd1;
    end else begin
      s10_bmon = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[10]) begin
      s10_tod_r  <= s9_tod_r;
      s10_diy_r  <= s9_diy_r;
      s10_ymar_r <= s9_ymar_r;
      s10_leap_r <= s9_leap_r;
      s10_r2_r   <= 6'(s9_r1_r - 8'(s10_bmon) * 8'(DAYS_PER_2MON));
      s10_mon_r  <= 4'(4'(s9_qmon_r) * 4'd5 + 4'(s10_bmon) * 4'd2);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: month split, shift to January-based calendar, output register
  // --------------------------------------------------------------------------
  logic        s11_m;
  logic [3:0]  s11_mon;
  logic [4:0]  s11_mday;
  logic [3:0]  s11_mon_out;
  logic [7:0]  s11_year_out;
  logic [8:0]  s11_yday_out;
  tod_t        s11_tod_r;
  logic [4:0]  s11_mday_r;
  logic [3:0]  s11_mon_r;
  logic [7:0]  s11_year_r;
  logic [8:0]  s11_yday_r;

  always_comb begin
    s11_m    = (s10_r2_r >= 6'(DAYS_PER_MON));
    s11_mday = 5'(s10_r2_r - (s11_m ? 6'(DAYS_PER_MON) : 6'd0) + 6'd1);
    s11_mon  = s10_mon_r + 4'(s11_m);
    // January and February belong to the next calendar year
    if (s11_mon >= MON_JAN_MAR) begin
      s11_mon_out  = s11_mon - MON_JAN_MAR;
      s11_year_out = s10_ymar_r + 8'd1;
      s11_yday_out = s10_diy_r - 9'(DAYS_MAR_TO_DEC);
    end else begin
      s11_mon_out  = s11_mon + MON_MAR_OFS;
      s11_year_out = s10_ymar_r;
      s11_yday_out = s10_diy_r + 9'(DAYS_JAN_FEB) + 9'(s10_leap_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[11]) begin
      s11_tod_r  <= s10_tod_r;
      s11_mday_r <= s11_mday;
      s11_mon_r  <= s11_mon_out;
      s11_year_r <= s11_year_out;
      s11_yday_r <= s11_yday_out;
    end
  end

  assign out_second           = s11_tod_r.second;
  assign out_minute           = s11_tod_r.minute;
  assign out_hour             = s11_tod_r.hour;
  assign out_weekday          = s11_tod_r.weekday;
  assign out_month_day        = s11_mday_r;
  assign out_month_index      = s11_mon_r;
  assign out_years_since_1900 = s11_year_r;
  assign out_year_day         = s11_yday_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ESU_ASSERT_IMP(a_tod_range, out_valid,
    out_second < 6'd60 && out_minute < 6'd60 && out_hour < 5'd24 && out_weekday < 3'd7,
    "time of day field out of range")
  `ESU_ASSERT_IMP(a_date_range, out_valid,
    out_month_day != 5'd0 && out_month_index < 4'd12 && out_year_day <= 9'd365 &&
    out_years_since_1900 >= 8'd70 && out_years_since_1900 <= 8'd206,
    "date field out of range")
  `ESU_ASSERT_IMP(a_jan_yday, out_valid && out_month_index == 4'd0,
    out_year_day == 9'(out_month_day) - 9'd1,
    "January day of year disagrees with day of month")
  `ESU_ASSERT_NXT(a_entry, in_valid && !in_stall, v_r[1], "accepted transaction missing from first stage")

endmodule

// File: tb/tb_epoch_seconds_to_utc_date.sv
// ----------------------------------------------------------------------------
// Testbench for epoch_seconds_to_utc_date
// Sends Unix timestamps through the valid/stall input channel and compares
// every calendar result with a behavioral predictor in order of arrival.
// Calendar corners come first, then random timestamps under random idling
// on both sides, plus one long output hold that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_utc_date;
  timeunit 1ns;
  timeprecision 1ps;

  // Calendar constants, days counted from 0000-03-01
  localparam int unsigned EPOCH_DAY_OFS  = 719468;
  localparam int unsigned ERA_DAYS       = 146097;
  localparam int unsigned CENTURY_DAYS   = 36524;
  localparam int unsigned QUAD_DAYS      = 1461;
  localparam int unsigned YEAR_DAYS      = 365;
  localparam int unsigned FIVE_MON_DAYS  = 153;
  localparam int unsigned TWO_MON_DAYS   = 61;
  localparam int unsigned MAR_DEC_DAYS   = 306;
  localparam int unsigned JAN_FEB_DAYS   = 59;
  localparam int unsigned LAST_FULL_DAY  = 49709;  // last day fully inside 32 bits
  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int          MAX_WAIT       = 18;
  localparam int          DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] month_day;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [8:0] year_day;
  } utc_date_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [2:0]  out_weekday;
  logic [4:0]  out_month_day;
  logic [3:0]  out_month_index;
  logic [7:0]  out_years_since_1900;
  logic [8:0]  out_year_day;

  utc_date_t pending_dates[$];
  int        mismatches = 0;
  int        in_gap_max = MAX_WAIT;
  int        out_gap_max = MAX_WAIT;
  int        hold_request = 0;

  epoch_seconds_to_utc_date dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_second           (out_second),
    .out_minute           (out_minute),
    .out_hour             (out_hour),
    .out_weekday          (out_weekday),
    .out_month_day        (out_month_day),
    .out_month_index      (out_month_index),
    .out_years_since_1900 (out_years_since_1900),
    .out_year_day         (out_year_day)
  );

  // Generate a 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Break a timestamp into the Gregorian date via the March-based calendar
  function automatic utc_date_t epoch_to_utc(input logic [31:0] stamp);
    int unsigned t, secs, mins, hrs, wday, days, era, doe, cent, doc, quad, doq;
    int unsigned yr, doy, yday, year, five, two, mon, mday, leap;
    utc_date_t r;
    t = stamp;
    secs = t % 60; t = t / 60;
    mins = t % 60; t = t / 60;
    hrs  = t % 24; t = t / 24;
    wday = (t + 4) % 7;
    days = t + EPOCH_DAY_OFS;
    era  = days / ERA_DAYS;
    doe  = days % ERA_DAYS;
    // Leap day closing a 400-year era is the last day of its final year
    if (doe == ERA_DAYS - 1) begin
      cent = 3;
      quad = 24;
      yr   = 3;
      doy  = 365;
    end else begin
      cent = doe / CENTURY_DAYS;
      doc  = doe % CENTURY_DAYS;
      quad = doc / QUAD_DAYS;
      doq  = doc % QUAD_DAYS;
      yr   = doq / YEAR_DAYS;
      // Leap day closing a 4-year cycle stays in year 3
      if (yr == 4) yr = 3;
      doy  = doq - yr * YEAR_DAYS;
    end
    year = yr + ((era * 4 + cent) * 25 + quad) * 4;
    yday = doy;
    five = doy / FIVE_MON_DAYS;
    doy  = doy % FIVE_MON_DAYS;
    two  = doy / TWO_MON_DAYS;
    doy  = doy % TWO_MON_DAYS;
    mon  = doy / 31 + five * 5 + two * 2;
    mday = doy % 31 + 1;
    // Shift from March-based months to the calendar year
    if (mon >= 10) begin
      year = year + 1;
      mon  = mon - 10;
      yday = yday - MAR_DEC_DAYS;
    end else begin
      mon  = mon + 2;
      leap = ((year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0))) ? 1 : 0;
      yday = yday + JAN_FEB_DAYS + leap;
    end
    r.second           = secs[5:0];
    r.minute           = mins[5:0];
    r.hour             = hrs[4:0];
    r.weekday          = wday[2:0];
    r.month_day        = mday[4:0];
    r.month_index      = mon[3:0];
    r.years_since_1900 = 8'(year - 1900);
    r.year_day         = yday[8:0];
    return r;
  endfunction

  function automatic int draw_wait(input int limit);
    return (limit == 0) ? 0 : int'($urandom_range(0, limit));
  endfunction

  function automatic int pick_gap_limit();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return MAX_WAIT;
    endcase
  endfunction

  // Random timestamp: uniform, near a midnight, or near either end of the range
  function automatic logic [31:0] pick_stamp();
    int unsigned day, ofs;
    day = $urandom_range(0, LAST_FULL_DAY);
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0:       ofs = 0;
          1:       ofs = 1;
          2:       ofs = SECS_PER_DAY - 1;
          default: ofs = $urandom_range(0, SECS_PER_DAY - 1);
        endcase
        return day * SECS_PER_DAY + ofs;
      end
      3:       return $urandom_range(0, 200000);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
    endcase
  endfunction

  // Offer one timestamp after a random gap; return at the accepting edge
  task automatic send_stamp(input logic [31:0] stamp);
    int   gap;
    logic stalled;
    gap = draw_wait(in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= stamp;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    pending_dates.push_back(epoch_to_utc(stamp));
  endtask

  task automatic test_calendar_corners();
    logic [31:0] corners [20] = '{
      32'd0,          // epoch start, Thursday
      32'd86399,      // last second of the first day
      32'd68169600,   // 1972-02-29, leap day closing a 4-year cycle
      32'd68255999,   // 1972-02-29 23:59:59
      32'd94608000,   // 1972-12-31, day 365 of a leap year
      32'd946684799,  // 1999-12-31 23:59:59
      32'd946684800,  // 2000-01-01
      32'd951782399,  // 2000-02-28 23:59:59
      32'd951782400,  // 2000-02-29, leap day closing a 400-year era
      32'd951868799,
      32'd951868800,  // 2000-03-01
      32'd978220800,  // 2000-12-31
      32'h7FFF_FFFF,  // 2038 rollover of signed time
      32'h8000_0000,
      32'h5555_5555,
      32'hAAAA_AAAA,
      32'd4107456000, // 2100-02-28, century year without leap day
      32'd4107542399,
      32'd4107542400, // 2100-03-01
      32'hFFFF_FFFF   // last representable second, 2106-02-07
    };
    in_gap_max  = MAX_WAIT;
    out_gap_max = MAX_WAIT;
    foreach (corners[i]) send_stamp(corners[i]);
  endtask

  task automatic test_random_stamps(input int count);
    for (int i = 0; i < count; i++) begin
      // Change the idling mix every few dozen transactions
      if (i % 48 == 0) begin
        in_gap_max  = pick_gap_limit();
        out_gap_max = pick_gap_limit();
      end
      send_stamp(pick_stamp());
    end
  endtask

  // Hold the output for a long stretch while offering back-to-back input
  task automatic test_output_backpressure();
    in_gap_max   = 0;
    out_gap_max  = 0;
    hold_request = 80;
    for (int i = 0; i < 40; i++) send_stamp(pick_stamp());
  endtask

  // Result receiver: random stall before each transaction, long hold on request
  initial begin
    int   n;
    logic seen;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = draw_wait(out_gap_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
      end while (!seen);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest expected date
  always @(posedge clk) begin
    utc_date_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual year %0d day %0d",
                 $time, out_years_since_1900, out_year_day);
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        check_field("second", want.second, out_second);
        check_field("minute", want.minute, out_minute);
        check_field("hour", want.hour, out_hour);
        check_field("weekday", want.weekday, out_weekday);
        check_field("month_day", want.month_day, out_month_day);
        check_field("month_index", want.month_index, out_month_index);
        check_field("years_since_1900", want.years_since_1900, out_years_since_1900);
        check_field("year_day", want.year_day, out_year_day);
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    out_stall        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calendar_corners();
    test_random_stamps(600);
    test_output_backpressure();
    test_random_stamps(600);

    // Drain, then allow the pipeline latency to pass
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: epoch_seconds_to_utc_date.f
+incdir+rtl
rtl/esu_pkg.sv
rtl/epoch_seconds_to_utc_date.sv
tb/tb_epoch_seconds_to_utc_date.sv
